[rtl/idsw_pkg.sv]
// Package for the display write sequencer: shared types, register indexes,
// bus phase codes and constants. No dependencies.
package idsw_pkg;

  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 16;

  localparam logic [7:0] SelectByte = 8'hE0;
  localparam logic [15:0] UnitTicksRst = 16'd10;
  localparam logic [9:0] HoldUnitsRst = 10'd1000;
  localparam logic [3:0] BitsPerByte = 4'd8;
  localparam logic [3:0] ClocksPerByte = 4'd9;
  localparam logic [1:0] LastByte = 2'd3;

  typedef enum logic [CfgIdxW-1:0] {
    RegDevAddr   = 2'd0,
    RegUnitTicks = 2'd1,
    RegHoldUnits = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    PhIdle    = 4'd0,
    PhStartA  = 4'd1,
    PhStartB  = 4'd2,
    PhStartC  = 4'd3,
    PhBitSet  = 4'd4,
    PhBitHigh = 4'd5,
    PhBitLow  = 4'd6,
    PhHold    = 4'd7,
    PhStopA   = 4'd8,
    PhStopB   = 4'd9,
    PhStopC   = 4'd10
  } phase_e;

  typedef struct packed {
    logic       is_cmd;
    logic [7:0] index;
    logic [7:0] value;
  } op_t;

  typedef struct packed {
    logic valid;
    op_t  op;
  } queue_head_t;

endpackage

[rtl/idsw_if.sv]
// Handshake channel interfaces for the display write sequencer: request,
// result and configuration write. Depends on idsw_pkg.
interface idsw_req_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] segment_index;
  logic [7:0] segment_value;
  modport source (output valid, req_type, segment_index, segment_value, input ready);
  modport sink (input valid, req_type, segment_index, segment_value, output ready);
endinterface

interface idsw_res_if;
  logic valid;
  logic ready;
  logic scl;
  logic sda;
  logic busy_res;
  modport source (output valid, scl, sda, busy_res, input ready);
  modport sink (input valid, scl, sda, busy_res, output ready);
endinterface

interface idsw_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [idsw_pkg::CfgIdxW-1:0]  index;
  logic [idsw_pkg::CfgDataW-1:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

[rtl/idsw_front.sv]
// Front end: accepts request items, classifies them as tick or write
// command and holds them in a two-entry queue. Depends on idsw_pkg, idsw_if.
module idsw_front (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  idsw_req_if.sink              req_i,
  output idsw_pkg::queue_head_t head_o,
  input  logic                  pop_i
);
  import idsw_pkg::*;

  op_t        entry_q [2];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       push;
  logic       pop;

  assign req_i.ready = (count_q != 2'd2);
  assign push = req_i.valid && req_i.ready;
  assign pop = pop_i && (count_q != 2'd0);

  assign head_o.valid = (count_q != 2'd0);
  assign head_o.op = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    count_d = count_q + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= '{is_cmd: req_i.req_type, index: req_i.segment_index,
                             value: req_i.segment_value};
    end
  end

endmodule

[rtl/idsw_back.sv]
// Back end: holds the configuration registers, runs the bus sequencer on one
// queued item per cycle unless the result output stalls, and registers the result. Depends on idsw_pkg, idsw_if.
module idsw_back (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  idsw_cfg_if.sink              cfg_i,
  input  idsw_pkg::queue_head_t head_i,
  output logic                  pop_o,
  idsw_res_if.source            res_o
);
  import idsw_pkg::*;

  logic [7:0]  dev_addr_q;
  logic [15:0] unit_ticks_q;
  logic [9:0]  hold_units_q;

  phase_e      phase_q, phase_d;
  logic [3:0]  bit_cnt_q, bit_cnt_d;
  logic [1:0]  byte_cnt_q, byte_cnt_d;
  logic [7:0]  shift_q, shift_d;
  logic [7:0]  index_q, index_d;
  logic [7:0]  value_q, value_d;
  logic [15:0] tick_cnt_q, tick_cnt_d;
  logic [9:0]  unit_cnt_q, unit_cnt_d;
  logic        sda_q, sda_d;
  logic        scl_q, scl_d;
  logic        out_valid_q, out_valid_d;
  logic        out_scl_q, out_sda_q, out_busy_q;

  logic        pop;
  logic        step;
  logic [15:0] limit;
  logic [15:0] tick_inc;
  logic [9:0]  unit_inc;
  logic [7:0]  shift_nxt;
  logic [3:0]  bit_nxt;
  logic [1:0]  byte_nxt;
  logic [7:0]  next_byte;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_addr_q <= 8'd0;
      unit_ticks_q <= UnitTicksRst;
      hold_units_q <= HoldUnitsRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        RegDevAddr:   dev_addr_q <= cfg_i.data[7:0];
        RegUnitTicks: unit_ticks_q <= cfg_i.data;
        RegHoldUnits: hold_units_q <= cfg_i.data[9:0];
        default: ;
      endcase
    end
  end

  assign pop = head_i.valid && (!out_valid_q || res_o.ready);
  assign pop_o = pop;

  assign limit = (unit_ticks_q == 16'd0) ? 16'd1 : unit_ticks_q;
  assign tick_inc = tick_cnt_q + 16'd1;
  assign unit_inc = unit_cnt_q + 10'd1;
  assign shift_nxt = {shift_q[6:0], 1'b0};
  assign bit_nxt = bit_cnt_q + 4'd1;
  assign byte_nxt = byte_cnt_q + 2'd1;

  always_comb begin
    unique case (byte_nxt)
      2'd0:    next_byte = dev_addr_q;
      2'd1:    next_byte = SelectByte;
      2'd2:    next_byte = index_q;
      default: next_byte = value_q;
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    bit_cnt_d = bit_cnt_q;
    byte_cnt_d = byte_cnt_q;
    shift_d = shift_q;
    index_d = index_q;
    value_d = value_q;
    tick_cnt_d = tick_cnt_q;
    unit_cnt_d = unit_cnt_q;
    sda_d = sda_q;
    scl_d = scl_q;
    step = 1'b0;
    if (pop) begin
      if (head_i.op.is_cmd) begin
        if (phase_q == PhIdle) begin
          index_d = head_i.op.index;
          value_d = head_i.op.value;
          bit_cnt_d = 4'd0;
          byte_cnt_d = 2'd0;
          unit_cnt_d = 10'd0;
          tick_cnt_d = 16'd0;
          phase_d = PhStartA;
          sda_d = 1'b1;
          scl_d = 1'b1;
        end
      end else if (phase_q != PhIdle) begin
        if (tick_inc != 16'd0 && tick_inc < limit) begin
          tick_cnt_d = tick_inc;
        end else begin
          tick_cnt_d = 16'd0;
          if (phase_q == PhHold) begin
            unit_cnt_d = unit_inc;
            step = !(unit_inc != 10'd0 && unit_inc < hold_units_q);
          end else begin
            step = 1'b1;
          end
        end
        if (step) begin
          unique case (phase_q)
            PhStartA: begin
              phase_d = PhStartB;
              sda_d = 1'b0;
            end
            PhStartB: begin
              phase_d = PhStartC;
              scl_d = 1'b0;
            end
            PhStartC: begin
              phase_d = PhBitSet;
              byte_cnt_d = 2'd0;
              bit_cnt_d = 4'd0;
              shift_d = dev_addr_q;
              sda_d = dev_addr_q[7];
            end
            PhBitSet: begin
              phase_d = PhBitHigh;
              scl_d = 1'b1;
            end
            PhBitHigh: begin
              phase_d = PhBitLow;
              scl_d = 1'b0;
            end
            PhBitLow: begin
              if (bit_nxt < ClocksPerByte) begin
                phase_d = PhBitSet;
                shift_d = shift_nxt;
                bit_cnt_d = bit_nxt;
                sda_d = (bit_nxt < BitsPerByte) ? shift_nxt[7] : 1'b1;
              end else if (byte_cnt_q != LastByte) begin
                phase_d = PhBitSet;
                byte_cnt_d = byte_nxt;
                bit_cnt_d = 4'd0;
                shift_d = next_byte;
                sda_d = next_byte[7];
              end else begin
                shift_d = shift_nxt;
                bit_cnt_d = bit_nxt;
                if (hold_units_q == 10'd0) begin
                  phase_d = PhStopA;
                  sda_d = 1'b0;
                end else begin
                  phase_d = PhHold;
                  unit_cnt_d = 10'd0;
                end
              end
            end
            PhHold: begin
              phase_d = PhStopA;
              sda_d = 1'b0;
            end
            PhStopA: begin
              phase_d = PhStopB;
              scl_d = 1'b1;
            end
            PhStopB: begin
              phase_d = PhStopC;
              sda_d = 1'b1;
            end
            default: phase_d = PhIdle;
          endcase
        end
      end
    end
  end

  assign out_valid_d = pop || (out_valid_q && !res_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      bit_cnt_q <= 4'd0;
      byte_cnt_q <= 2'd0;
      shift_q <= 8'd0;
      index_q <= 8'd0;
      value_q <= 8'd0;
      tick_cnt_q <= 16'd0;
      unit_cnt_q <= 10'd0;
      sda_q <= 1'b1;
      scl_q <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      bit_cnt_q <= bit_cnt_d;
      byte_cnt_q <= byte_cnt_d;
      shift_q <= shift_d;
      index_q <= index_d;
      value_q <= value_d;
      tick_cnt_q <= tick_cnt_d;
      unit_cnt_q <= unit_cnt_d;
      sda_q <= sda_d;
      scl_q <= scl_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      out_scl_q <= scl_d;
      out_sda_q <= sda_d;
      out_busy_q <= (phase_d != PhIdle);
    end
  end

  assign res_o.valid = out_valid_q;
  assign res_o.scl = out_scl_q;
  assign res_o.sda = out_sda_q;
  assign res_o.busy_res = out_busy_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhIdle) |-> (scl_q && sda_q))
    else $error("Bus lines not released while idle.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !head_i.op.is_cmd && phase_q == PhIdle) |=> (phase_q == PhIdle))
    else $error("Tick while idle left the idle phase.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhBitSet || phase_q == PhBitHigh || phase_q == PhBitLow)
      |-> (bit_cnt_q < ClocksPerByte))
    else $error("Bit counter ran past the acknowledge clock.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PhBitHigh) |-> scl_q)
    else $error("Clock line low during the high half of a bit.");
`endif

endmodule

[rtl/i2c_display_write_sequencer.sv]
// Top level of the display write sequencer: request queue front end and
// bus sequencer back end. Depends on idsw_pkg, idsw_if, idsw_front, idsw_back.
//
// Usage: req_i carries tick items (req_type 0) and write commands
// (req_type 1 with segment_index and segment_value). A command is taken up
// only while no transaction runs; otherwise it is dropped but still yields
// a result. Every request item yields exactly one result item on res_o with
// the SCL and SDA levels and the busy flag after that item.
// cfg_i writes device_address (index 0), unit_ticks (1) and hold_units (2);
// it is always ready and a write takes effect at once, also during a
// transaction, so it should be used only while no item is queued or held.
// Throughput: one item per cycle while res_o is ready. A result passes the
// request queue and then the result register behind the sequencer step.
// When res_o stalls, the result register holds, the queue fills and req_i
// ready drops after two more items; it rises again as results drain.
// Reset clears the queue and result register and returns the sequencer to
// idle with both lines high and the registers at their reset values.
module i2c_display_write_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  idsw_req_if.sink    req_i,
  idsw_res_if.source  res_o,
  idsw_cfg_if.sink    cfg_i
);
  import idsw_pkg::*;

  queue_head_t head;
  logic        pop;

  idsw_front u_front (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .head_o (head),
    .pop_i  (pop)
  );

  idsw_back u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .head_i (head),
    .pop_o  (pop),
    .res_o  (res_o)
  );

endmodule
